[design/sfr_pkg.sv]
`default_nettype none

package sfr_pkg;

	localparam int MAX_LENGTH = 512;
	localparam int POS_W      = $clog2(MAX_LENGTH + 2);
	localparam int LIMIT_W    = 10;
	localparam int TICKS_W    = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_WORD     = 2'd0,
		REG_END_WORD      = 2'd1,
		REG_LENGTH_LIMIT  = 2'd2,
		REG_TIMEOUT_TICKS = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TIMEOUT   = 3'd1,
		ST_FOOTER    = 3'd2,
		ST_CRC       = 3'd3,
		ST_LENGTH    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_LEN  = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	typedef struct packed {
		logic [15:0]        sync_word;
		logic [15:0]        end_word;
		logic [LIMIT_W-1:0] length_limit;
		logic [TICKS_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  frame_type;
		logic [7:0]  data_byte;
		status_t     status;
		logic [15:0] frame_length;
		logic [15:0] crc_received;
		logic        last;
	} out_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[design/sfr_cfg.sv]
`default_nettype none

module sfr_cfg
	import sfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_word     <= '0;
			cfg_q.end_word      <= '0;
			cfg_q.length_limit  <= LIMIT_W'(512);
			cfg_q.timeout_ticks <= TICKS_W'(100000);
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_SYNC_WORD:     cfg_q.sync_word     <= cfg_wdata[15:0];
				REG_END_WORD:      cfg_q.end_word      <= cfg_wdata[15:0];
				REG_LENGTH_LIMIT:  cfg_q.length_limit  <= cfg_wdata[LIMIT_W-1:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[design/sfr_engine.sv]
`default_nettype none

module sfr_engine
	import sfr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire in_t  item,
	input  wire logic fire,
	output logic      has_res,
	output out_t      res
);

	phase_t             phase_q, phase_d;
	logic [7:0]         prev_q, prev_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [15:0]        len_q, len_d;
	logic [7:0]         type_q, type_d;
	logic [15:0]        crc_run_q, crc_run_d;
	logic [15:0]        crc_car_q, crc_car_d;
	logic [7:0]         end_hi_q, end_hi_d;
	logic [TICKS_W-1:0] ticks_q, ticks_d;

	logic [TICKS_W-1:0] ticks_inc;
	logic [15:0]        limit;
	logic [15:0]        pos16;
	logic [15:0]        len_new;
	logic [15:0]        crc_fed;
	logic               kind;
	logic [7:0]         data_out;
	status_t            status;
	logic [15:0]        crc_out;

	always_comb begin
		phase_d   = phase_q;
		prev_d    = prev_q;
		pos_d     = pos_q;
		len_d     = len_q;
		type_d    = type_q;
		crc_run_d = crc_run_q;
		crc_car_d = crc_car_q;
		end_hi_d  = end_hi_q;
		ticks_d   = ticks_q;
		has_res   = 1'b0;
		kind      = KIND_STATUS;
		data_out  = '0;
		status    = ST_OK;
		crc_out   = '0;

		ticks_inc = ticks_q + TICKS_W'(1);
		limit     = (16'(cfg.length_limit) > 16'(MAX_LENGTH)) ? 16'(MAX_LENGTH)
			: 16'(cfg.length_limit);
		pos16     = 16'(pos_q);
		len_new   = {len_q[15:8], item.rx_byte};
		crc_fed   = crc_feed(crc_run_q, item.rx_byte);

		if (item.op == OP_TICK) begin
			if (phase_q != PH_HUNT) begin
				ticks_d = ticks_inc;
				if (ticks_inc >= cfg.timeout_ticks || ticks_inc == '0) begin
					has_res = 1'b1;
					status  = ST_TIMEOUT;
					crc_out = (phase_q == PH_BODY && pos16 >= len_q) ? crc_car_q : '0;
					phase_d = PH_HUNT;
					pos_d   = '0;
					ticks_d = '0;
				end
			end
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					prev_d = item.rx_byte;
					if (pos_q != '0 && prev_q == cfg.sync_word[15:8]
						&& item.rx_byte == cfg.sync_word[7:0]) begin
						len_d     = '0;
						type_d    = '0;
						crc_run_d = '0;
						crc_car_d = '0;
						end_hi_d  = '0;
						phase_d   = PH_LEN;
						pos_d     = '0;
						ticks_d   = '0;
					end else begin
						pos_d = POS_W'(1);
					end
				end
				PH_LEN: begin
					crc_run_d = crc_fed;
					if (pos_q == '0) begin
						len_d = {item.rx_byte, 8'h00};
						pos_d = POS_W'(1);
					end else begin
						len_d   = len_new;
						pos_d   = '0;
						ticks_d = '0;
						if (len_new < 16'd3 || len_new > limit) begin
							has_res = 1'b1;
							status  = ST_LENGTH;
							phase_d = PH_HUNT;
						end else begin
							phase_d = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					pos_d = pos_q + POS_W'(1);
					if (pos_q == '0) begin
						type_d    = item.rx_byte;
						crc_run_d = crc_fed;
					end else if (pos16 < len_q - 16'd2) begin
						crc_run_d = crc_fed;
						has_res   = 1'b1;
						kind      = KIND_DATA;
						data_out  = item.rx_byte;
					end else if (pos16 == len_q - 16'd2) begin
						crc_car_d = {item.rx_byte, 8'h00};
					end else if (pos16 == len_q - 16'd1) begin
						crc_car_d = {crc_car_q[15:8], item.rx_byte};
					end else if (pos16 == len_q) begin
						end_hi_d = item.rx_byte;
					end else begin
						has_res = 1'b1;
						crc_out = crc_car_q;
						if ({end_hi_q, item.rx_byte} != cfg.end_word) begin
							status = ST_FOOTER;
						end else if (crc_car_q != crc_run_q) begin
							status = ST_CRC;
						end else begin
							status = ST_OK;
						end
						phase_d = PH_HUNT;
						pos_d   = '0;
						ticks_d = '0;
					end
				end
				default: begin
					phase_d = PH_HUNT;
					pos_d   = '0;
					ticks_d = '0;
				end
			endcase
		end

		res.kind         = kind;
		res.frame_type   = type_d;
		res.data_byte    = data_out;
		res.status       = status;
		res.frame_length = len_d;
		res.crc_received = crc_out;
		res.last         = (kind == KIND_STATUS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			prev_q    <= '0;
			pos_q     <= '0;
			len_q     <= '0;
			type_q    <= '0;
			crc_run_q <= '0;
			crc_car_q <= '0;
			end_hi_q  <= '0;
			ticks_q   <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			prev_q    <= prev_d;
			pos_q     <= pos_d;
			len_q     <= len_d;
			type_q    <= type_d;
			crc_run_q <= crc_run_d;
			crc_car_q <= crc_car_d;
			end_hi_q  <= end_hi_d;
			ticks_q   <= ticks_d;
		end
	end

	as_hunt_no_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HUNT |-> ticks_q == '0)
		else $error("tick count running while hunting");

	as_body_length: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> len_q >= 16'd3 && len_q <= 16'(MAX_LENGTH))
		else $error("body phase with out of range length");

	as_body_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> pos16 <= len_q + 16'd1)
		else $error("body position past end of frame");

endmodule

`default_nettype wire

[design/serial_frame_receiver_crc16_top.sv]
// channel  dir  handshake              payload
// cfg      in   cfg_we                 cfg_index, cfg_wdata
// in       in   in_valid / in_stall    in_data (op, rx_byte)
// out      out  out_valid / out_stall  out_data (kind .. last)
//
// one item per cycle while in_stall stays low
// items pass an input register, then the frame state update and crc step
// run combinationally into the output register
// arst_n clears the hunt state, counters and both valid flags at once
// in_stall rises only while the output register holds a result that is stalled
// and the item in the input register has a result of its own
`default_nettype none

module serial_frame_receiver_crc16_top
	import sfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_t                   in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_t                       out_data
);

	cfg_t cfg;
	logic valid_s1;
	in_t  item_s1;
	logic has_res;
	out_t res;
	logic out_free;
	logic advance;
	logic out_valid_q;
	out_t out_data_q;

	sfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sfr_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.fire    (advance),
		.has_res (has_res),
		.res     (res)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!has_res || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && has_res) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	as_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	as_data_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind == KIND_DATA |-> !out_data.last && out_data.status == ST_OK)
		else $error("data result flagged as frame end");

	as_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule

`default_nettype wire
